FILE: sv/sobel_edge_threshold_top_macros.svh
// Assertion macros for the Sobel edge threshold block.
`ifndef SOBEL_EDGE_THRESHOLD_TOP_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_TOP_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge out of reset.
`define SOBEL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sobel_edge_threshold: check failed");
// Condition in one cycle implies consequence in the next.
`define SOBEL_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("sobel_edge_threshold: sequence check failed");
`else
`define SOBEL_ASSERT(label, prop)
`define SOBEL_ASSERT_NEXT(label, cond, conseq)
`endif

`endif

FILE: sv/sobel_pkg.sv
// Shared types, constants and helper functions of the Sobel edge threshold block.
package sobel_pkg;

  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 4096;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int COLS_W   = $clog2(MAX_COLS + 1);
  localparam int ROW_W    = $clog2(MAX_ROWS + 1);

  localparam int ROWS_CFG_W  = 13;
  localparam int COLS_CFG_W  = 12;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_ENABLE = 3'd3;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  localparam logic [7:0] PIX_MAX = 8'd255;

  localparam logic [ROW_W-1:0]  ROWS_RESET  = ROW_W'(480);
  localparam logic [COLS_W-1:0] COLS_RESET  = COLS_W'(640);
  localparam logic [7:0]        LEVEL_RESET = 8'd100;

  typedef struct packed {
    logic       mode;
    logic [7:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] edge_pixel;
    logic       frame_last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] level;
    logic       enable;
  } thresh_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic             is_pix;
    logic             emit;
    logic             zero;
    logic             last;
    logic [COL_W-1:0] col;
    logic [7:0]       pix;
  } queue_entry_t;

  typedef struct packed {
    logic valid;
    logic is_pix;
    logic emit;
    logic zero;
    logic last;
  } meta_t;

  typedef struct packed {
    logic [15:0] rad;
    logic [9:0]  rem;
    logic [7:0]  root;
  } sqrt_t;

  typedef struct packed {
    meta_t m;
    logic  sat;
    sqrt_t s;
  } root_stage_t;

  function automatic logic [ROW_W-1:0] clamp_rows(input logic [ROWS_CFG_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (v == '0) begin
      r = ROW_W'(1);
    end else if (32'(v) > MAX_ROWS) begin
      r = ROW_W'(MAX_ROWS);
    end else begin
      r = ROW_W'(v);
    end
    return r;
  endfunction

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_CFG_W-1:0] v);
    logic [COLS_W-1:0] c;
    if (v == '0) begin
      c = COLS_W'(1);
    end else if (32'(v) > MAX_COLS) begin
      c = COLS_W'(MAX_COLS);
    end else begin
      c = COLS_W'(v);
    end
    return c;
  endfunction

  // Two digits of the restoring integer square root, no multiplier.
  function automatic sqrt_t sqrt_pair(input sqrt_t s);
    sqrt_t       o;
    logic [11:0] r;
    logic [11:0] trial;
    o = s;
    for (int i = 0; i < 2; i++) begin
      r     = {o.rem, o.rad[15:14]};
      trial = {2'b00, o.root, 2'b01};
      if (r >= trial) begin
        r      = r - trial;
        o.root = {o.root[6:0], 1'b1};
      end else begin
        o.root = {o.root[6:0], 1'b0};
      end
      o.rem = r[9:0];
      o.rad = {o.rad[13:0], 2'b00};
    end
    return o;
  endfunction

endpackage

FILE: sv/sobel_queue.sv
// Short queue of classified items between the front and the back.
module sobel_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sobel_pkg::queue_entry_t push_entry,
  input  logic                    pop,
  output sobel_pkg::queue_entry_t pop_entry,
  output sobel_pkg::q_status_t    status
);

  sobel_pkg::queue_entry_t entries [sobel_pkg::QUEUE_DEPTH];
  logic [sobel_pkg::QPTR_W-1:0] wr_ptr;
  logic [sobel_pkg::QPTR_W-1:0] rd_ptr;
  logic [sobel_pkg::QCNT_W-1:0] count;

  assign status.full  = (count == sobel_pkg::QCNT_W'(sobel_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/sobel_front.sv
// Front end: configuration registers, raster position tracking and item classification.
module sobel_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sobel_pkg::in_beat_t                  in_data,
  input  sobel_pkg::q_status_t                 q_stat,
  output logic                                 push,
  output sobel_pkg::queue_entry_t              push_entry,
  output sobel_pkg::thresh_cfg_t               thr
);

  logic [sobel_pkg::ROW_W-1:0]  rows_u;
  logic [sobel_pkg::COLS_W-1:0] cols_u;
  logic [sobel_pkg::COL_W-1:0]  cols_m1;
  logic [7:0]                   level;
  logic                         thr_en;

  logic [sobel_pkg::COL_W-1:0]  col, col_next;
  logic [sobel_pkg::ROW_W-1:0]  row, row_next;
  logic [sobel_pkg::COLS_W-1:0] drain, drain_next;

  logic accept;
  logic frame_in;
  logic geom_write;
  logic drain_last;

  assign in_ready   = !q_stat.full;
  assign accept     = in_valid && in_ready;
  assign frame_in   = (row >= rows_u);
  assign geom_write = cfg_write &&
                      ((cfg_index == sobel_pkg::REG_FRAME_ROWS) ||
                       (cfg_index == sobel_pkg::REG_FRAME_COLS));
  assign drain_last = (drain == cols_u);
  assign thr.level  = level;
  assign thr.enable = thr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_u  <= sobel_pkg::ROWS_RESET;
      cols_u  <= sobel_pkg::COLS_RESET;
      cols_m1 <= sobel_pkg::COL_W'(sobel_pkg::COLS_RESET - 1'b1);
      level   <= sobel_pkg::LEVEL_RESET;
      thr_en  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        sobel_pkg::REG_FRAME_ROWS: begin
          rows_u <= sobel_pkg::clamp_rows(cfg_data[sobel_pkg::ROWS_CFG_W-1:0]);
        end
        sobel_pkg::REG_FRAME_COLS: begin
          cols_u  <= sobel_pkg::clamp_cols(cfg_data[sobel_pkg::COLS_CFG_W-1:0]);
          cols_m1 <= sobel_pkg::COL_W'(
                       sobel_pkg::clamp_cols(cfg_data[sobel_pkg::COLS_CFG_W-1:0]) - 1'b1);
        end
        sobel_pkg::REG_THRESHOLD_LEVEL: begin
          level <= cfg_data[7:0];
        end
        sobel_pkg::REG_THRESHOLD_ENABLE: begin
          thr_en <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_next          = col;
    row_next          = row;
    drain_next        = drain;
    push              = 1'b0;
    push_entry.is_pix = 1'b0;
    push_entry.emit   = 1'b0;
    push_entry.zero   = 1'b1;
    push_entry.last   = 1'b0;
    push_entry.col    = col;
    push_entry.pix    = in_data.pixel;
    if (accept) begin
      if (in_data.mode == sobel_pkg::MODE_PIXEL) begin
        if (!frame_in) begin
          push              = 1'b1;
          push_entry.is_pix = 1'b1;
          // first cols+1 pixels have no result position yet
          push_entry.emit   = !((row == '0) ||
                                ((row == sobel_pkg::ROW_W'(1)) && (col == '0)));
          // result sits one row and one column back: interior iff row>=2, col>=2
          push_entry.zero   = !((row >= sobel_pkg::ROW_W'(2)) &&
                                (col >= sobel_pkg::COL_W'(2)));
          if (col == cols_m1) begin
            col_next = '0;
            row_next = row + 1'b1;
          end else begin
            col_next = col + 1'b1;
          end
        end
      end else begin
        if (frame_in) begin
          // single-row frames owe one result fewer than drain beats
          push            = (rows_u != sobel_pkg::ROW_W'(1)) || (drain != '0);
          push_entry.emit = 1'b1;
          push_entry.last = drain_last;
          drain_next      = drain + 1'b1;
          if (drain_last) begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      col   <= '0;
      row   <= '0;
      drain <= '0;
    end else begin
      col   <= col_next;
      row   <= row_next;
      drain <= drain_next;
    end
  end

endmodule

FILE: sv/sobel_back.sv
// Back end: line stores, 3x3 window, Sobel gradients, square root and output register.
module sobel_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sobel_pkg::q_status_t    q_stat,
  input  sobel_pkg::queue_entry_t q_entry,
  output logic                    pop,
  input  sobel_pkg::thresh_cfg_t  thr,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sobel_pkg::out_beat_t    out_data
);

  logic [7:0] upper_mem  [sobel_pkg::MAX_COLS];
  logic [7:0] middle_mem [sobel_pkg::MAX_COLS];
  logic [7:0] up_q, mid_q;

  logic                        en;
  sobel_pkg::meta_t            s1_m, s2_m, s3_m;
  logic [sobel_pkg::COL_W-1:0] s1_col;
  logic [7:0]                  s1_pix;
  logic [7:0]                  win [3][3];
  logic [9:0]                  gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [10:0]          gx_c, gy_c, gx_r, gy_r;
  logic signed [21:0]          px, py;
  logic [21:0]                 sq_c;
  sobel_pkg::root_stage_t      s4;
  sobel_pkg::root_stage_t      rq [4];
  logic [7:0]                  mag, val, res;

  // whole pipeline advances together; holds while the output beat is stalled
  assign en  = !out_valid || out_ready;
  assign pop = en && !q_stat.empty;

  // Upper store takes mid_q as the item leaves stage one. With a one-column frame
  // the read can miss that write, but then every result is a border zero.
  always_ff @(posedge clk) begin
    if (en) begin
      if (pop && q_entry.is_pix) begin
        up_q                    <= upper_mem[q_entry.col];
        mid_q                   <= middle_mem[q_entry.col];
        middle_mem[q_entry.col] <= q_entry.pix;
      end
      if (s1_m.valid && s1_m.is_pix) begin
        upper_mem[s1_col] <= mid_q;
      end
    end
  end

  always_comb begin
    gx_pos = {2'b00, win[0][2]} + {1'b0, win[1][2], 1'b0} + {2'b00, win[2][2]};
    gx_neg = {2'b00, win[0][0]} + {1'b0, win[1][0], 1'b0} + {2'b00, win[2][0]};
    gy_pos = {2'b00, win[2][0]} + {1'b0, win[2][1], 1'b0} + {2'b00, win[2][2]};
    gy_neg = {2'b00, win[0][0]} + {1'b0, win[0][1], 1'b0} + {2'b00, win[0][2]};
    gx_c   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    gy_c   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    px     = gx_r * gx_r;
    py     = gy_r * gy_r;
    sq_c   = $unsigned(px) + $unsigned(py);
  end

  always_comb begin
    mag = rq[3].sat ? sobel_pkg::PIX_MAX : rq[3].s.root;
    val = rq[3].m.zero ? 8'h00 : mag;
    if (thr.enable) begin
      res = (val > thr.level) ? sobel_pkg::PIX_MAX : 8'h00;
    end else begin
      res = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_m.valid   <= 1'b0;
      s2_m.valid   <= 1'b0;
      s3_m.valid   <= 1'b0;
      s4.m.valid   <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        rq[i].m.valid <= 1'b0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= 8'h00;
        end
      end
      out_valid <= 1'b0;
    end else if (en) begin
      s1_m.valid  <= pop;
      s1_m.is_pix <= q_entry.is_pix;
      s1_m.emit   <= q_entry.emit;
      s1_m.zero   <= q_entry.zero;
      s1_m.last   <= q_entry.last;
      s1_col      <= q_entry.col;
      s1_pix      <= q_entry.pix;

      s2_m <= s1_m;
      if (s1_m.valid && s1_m.is_pix) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_q;
        win[1][2] <= mid_q;
        win[2][2] <= s1_pix;
      end

      s3_m <= s2_m;
      gx_r <= gx_c;
      gy_r <= gy_c;

      s4.m      <= s3_m;
      s4.sat    <= |sq_c[21:16];
      s4.s.rad  <= sq_c[15:0];
      s4.s.rem  <= '0;
      s4.s.root <= '0;

      rq[0].m   <= s4.m;
      rq[0].sat <= s4.sat;
      rq[0].s   <= sobel_pkg::sqrt_pair(s4.s);
      for (int i = 1; i < 4; i++) begin
        rq[i].m   <= rq[i-1].m;
        rq[i].sat <= rq[i-1].sat;
        rq[i].s   <= sobel_pkg::sqrt_pair(rq[i-1].s);
      end

      out_valid           <= rq[3].m.valid && rq[3].m.emit;
      out_data.edge_pixel <= res;
      out_data.frame_last <= rq[3].m.last;
    end
  end

endmodule

FILE: sv/sobel_edge_threshold_top.sv
// Top level of the streaming Sobel edge magnitude and threshold block.
// Input channel (in_valid/in_ready/in_data): one beat per pixel in raster order,
// mode 0 with a grey pixel, or mode 1 as a drain beat once the frame is in.
// Output channel (out_valid/out_ready/out_data): one edge value per raster
// position, lagging the input by frame_cols+1 pixels; frame_cols+1 drain beats
// flush the tail and the final beat carries frame_last.
// Config port: cfg_write with cfg_index/cfg_data writes one register per cycle;
// write only while idle. A geometry write restarts the frame.
// Throughput: one beat per cycle when out_ready stays high. The front queue
// accepts while the back is stalled until its four entries are full.
// From input accept to the output beat for the same item, an item passes the queue,
// the line store read, window, gradient, square, four square-root stages (two root
// digits each) and the output register.
// Stall: an output beat held by a low out_ready freezes the whole back pipeline.
// Reset (rst, synchronous): positions, window and valid bits clear; registers
// return to 480 rows, 640 columns, threshold 100 enabled. Line stores are not
// cleared; unwritten entries only feed border results.
module sobel_edge_threshold_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sobel_pkg::in_beat_t              in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sobel_pkg::out_beat_t             out_data
);

`include "sobel_edge_threshold_top_macros.svh"

  logic                    push;
  logic                    pop;
  sobel_pkg::queue_entry_t push_entry;
  sobel_pkg::queue_entry_t pop_entry;
  sobel_pkg::q_status_t    q_stat;
  sobel_pkg::thresh_cfg_t  thr;

  sobel_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry),
    .thr        (thr)
  );

  sobel_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_stat)
  );

  sobel_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_entry   (pop_entry),
    .pop       (pop),
    .thr       (thr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SOBEL_ASSERT(a_no_push_when_full, !(push && q_stat.full))
  `SOBEL_ASSERT(a_no_pop_when_empty, !(pop && q_stat.empty))
  `SOBEL_ASSERT_NEXT(a_stall_holds_pop, out_valid && !out_ready, !pop || out_ready || !out_valid)

endmodule
